// ===== sv/bchd_pkg.sv =====
// Shared types and constants for the button click and hold detector.
package bchd_pkg;

  localparam int unsigned TimeWidth = 32;
  localparam int unsigned MsWidth = 16;
  localparam int unsigned CfgIndexWidth = 2;

  localparam logic [MsWidth-1:0] DebounceMsReset = 16'd70;
  localparam logic [MsWidth-1:0] HoldMsReset = 16'd2000;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_DEBOUNCE_MS = 2'd0,
    REG_HOLD_MS     = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic                 button_level;
    logic [TimeWidth-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic click_event;
    logic hold_event;
  } out_item_t;

  typedef struct packed {
    logic [MsWidth-1:0] debounce_ms;
    logic [MsWidth-1:0] hold_ms;
  } cfg_t;

endpackage

// ===== sv/button_click_hold_detector.sv =====
// Top level of the button click and hold detector: input register, decision core, result register.
// Button click and hold detector. Each transaction carries one button sample and
// its millisecond timestamp and produces exactly one result transaction with a click
// and a hold flag. The block takes one sample per clock cycle unless the result register
// stalls. An accepted sample is held in the input register and is then written into the
// result register, from which it is taken when out_ready is high. The rate is set by the
// compare and update of the button state registers. Both channels stall cleanly under
// backpressure. The user must write debounce and hold times through the configuration port
// only while no transaction is in flight; the block itself does not enforce this.
module button_click_hold_detector (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bchd_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bchd_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [bchd_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [bchd_pkg::MsWidth-1:0]       cfg_data
);

  logic                s1_valid;
  bchd_pkg::in_item_t  s1_data;
  logic                s1_advance;
  bchd_pkg::cfg_t      cfg;
  bchd_pkg::out_item_t result;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_advance;

  bchd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bchd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_advance),
    .item    (s1_data),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data <= result;
    end
  end

  // A click and a hold come from opposite button levels.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.click_event && out_data.hold_event))
    else $error("click and hold in the same result");

  // Every sample that leaves the input register shows up as a result.
  assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> out_valid)
    else $error("result register missed a sample");

  // An empty input register always takes a new transaction.
  assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stalled while the input register is empty");

endmodule

// ===== sv/bchd_cfg.sv =====
// Configuration register file for the debounce and hold times.
module bchd_cfg (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [bchd_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [bchd_pkg::MsWidth-1:0]          cfg_data,
  output bchd_pkg::cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms <= bchd_pkg::DebounceMsReset;
      cfg.hold_ms <= bchd_pkg::HoldMsReset;
    end else if (cfg_we) begin
      case (bchd_pkg::cfg_reg_t'(cfg_index))
        bchd_pkg::REG_DEBOUNCE_MS: cfg.debounce_ms <= cfg_data;
        bchd_pkg::REG_HOLD_MS: cfg.hold_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/bchd_core.sv =====
// Button state registers and the edge, debounce and hold decision logic.
module bchd_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  bchd_pkg::in_item_t  item,
  input  bchd_pkg::cfg_t      cfg,
  output bchd_pkg::out_item_t result
);

  logic                           last_level;
  logic [bchd_pkg::TimeWidth-1:0] release_time;
  logic [bchd_pkg::TimeWidth-1:0] press_time;
  logic                           suppress_release;

  logic                           last_level_next;
  logic [bchd_pkg::TimeWidth-1:0] release_time_next;
  logic [bchd_pkg::TimeWidth-1:0] press_time_next;
  logic                           suppress_release_next;

  logic [bchd_pkg::TimeWidth-1:0] since_release;
  logic [bchd_pkg::TimeWidth-1:0] since_press;
  logic [bchd_pkg::TimeWidth-1:0] since_press_eff;
  logic [bchd_pkg::TimeWidth-1:0] debounce_ext;
  logic [bchd_pkg::TimeWidth-1:0] hold_ext;
  logic                           fall_ok;
  logic                           rise_ok;
  logic                           hold_hit;

  always_comb begin
    debounce_ext = {{(bchd_pkg::TimeWidth - bchd_pkg::MsWidth){1'b0}}, cfg.debounce_ms};
    hold_ext = {{(bchd_pkg::TimeWidth - bchd_pkg::MsWidth){1'b0}}, cfg.hold_ms};
    since_release = item.now_ms - release_time;
    since_press = item.now_ms - press_time;

    fall_ok = !item.button_level && last_level && (since_release > debounce_ext);
    rise_ok = item.button_level && !last_level && (since_press > debounce_ext);

    // An accepted press restarts the press time before the hold test looks at it.
    since_press_eff = fall_ok ? '0 : since_press;
    hold_hit = !item.button_level && (since_press_eff > hold_ext);

    last_level_next = item.button_level;
    release_time_next = rise_ok ? item.now_ms : release_time;
    press_time_next = (fall_ok || hold_hit) ? item.now_ms : press_time;
    suppress_release_next = suppress_release;
    if (rise_ok) begin
      suppress_release_next = 1'b0;
    end
    if (hold_hit) begin
      suppress_release_next = 1'b1;
    end

    result.click_event = rise_ok && !suppress_release;
    result.hold_event = hold_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level <= 1'b1;
      release_time <= '0;
      press_time <= '0;
      suppress_release <= 1'b0;
    end else if (advance) begin
      last_level <= last_level_next;
      release_time <= release_time_next;
      press_time <= press_time_next;
      suppress_release <= suppress_release_next;
    end
  end

  // A hold always leaves the next release suppressed.
  assert property (@(posedge clk) disable iff (rst)
    advance && result.hold_event |=> suppress_release)
    else $error("hold did not set release suppression");

  // A click can only come from a released sample after a pressed one.
  assert property (@(posedge clk) disable iff (rst)
    result.click_event |-> item.button_level && !last_level)
    else $error("click without a rising edge");

  // The press time only moves on a pressed sample.
  assert property (@(posedge clk) disable iff (rst)
    advance && item.button_level |=> $stable(press_time))
    else $error("press time changed on a released sample");

endmodule
